// ===== design/mtxpow_pkg.sv =====
// ----------------------------------------------------------------------------
// mtxpow_pkg
// Shared types and codes for the matrix product and power block.
// ----------------------------------------------------------------------------
package mtxpow_pkg;

  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_t;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_ROWS_A     = 3'd1;
  localparam logic [2:0] REG_INNER_SIZE = 3'd2;
  localparam logic [2:0] REG_COLS_B     = 3'd3;
  localparam logic [2:0] REG_POWER_EXP  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_WRITE,
    ST_ORD,
    ST_OWAIT,
    ST_OSEND
  } state_t;

  typedef enum logic [1:0] {
    SRC_A,
    SRC_P0,
    SRC_P1
  } src_t;

endpackage

// ===== design/mtxpow_req_if.sv =====
// ----------------------------------------------------------------------------
// mtxpow_req_if
// Request channel: element loads and start commands.
// ----------------------------------------------------------------------------
interface mtxpow_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic signed [31:0] element_value;

  modport source (
    output valid, operation, row_index, col_index, element_value,
    input  ready
  );
  modport sink (
    input  valid, operation, row_index, col_index, element_value,
    output ready
  );
endinterface

// ===== design/mtxpow_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mtxpow_rsp_if
// Result channel: one result element per transfer, last element flagged.
// ----------------------------------------------------------------------------
interface mtxpow_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         result_row;
  logic [2:0]         result_col;
  logic               last;

  modport source (
    output valid, result_value, result_row, result_col, last,
    input  ready
  );
  modport sink (
    input  valid, result_value, result_row, result_col, last,
    output ready
  );
endinterface

// ===== design/mtxpow_ram.sv =====
// ----------------------------------------------------------------------------
// mtxpow_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtxpow_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/matrix_multiply_power_core.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_power_core: Q16.16 matrix product A*B or power A^e.
// One shared 32x32 multiplier and 64-bit accumulator compute each element as a
// sum of k products (k = inner size, m for a power); a power is (e-1) products,
// A itself for e <= 1. Each result is held valid until result.ready takes it.
// Reset clears control and registers (mode 0, others 1); stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_power_core
  import mtxpow_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  mtxpow_req_if.sink          req,
  mtxpow_rsp_if.source        result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int IW      = $clog2(DIM_LIM);

  function automatic logic [IW-1:0] dim_last(input logic [3:0] d);
    if (d == 4'd0) begin
      return '0;
    end else if (int'(d) > DIM_LIM) begin
      return IW'(DIM_LIM - 1);
    end
    return IW'(d - 4'd1);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // configuration registers
  logic       mode;
  logic [3:0] rows_a;
  logic [3:0] inner_size;
  logic [3:0] cols_b;
  logic [7:0] power_exponent;

  state_t state, state_next;

  logic [IW-1:0] row_cnt, col_cnt, k_cnt;
  logic [IW-1:0] m_last, k_last, p_last;
  logic [7:0]    mults_left;
  src_t          x_src, out_src, src_sel;
  logic          dst_p1;
  logic          rd_vld, prod_vld;
  logic [63:0]   acc;
  logic signed [63:0] prod, prod_shift, mul_full;

  logic signed [31:0] out_value;
  logic [IW-1:0]      out_row, out_col;
  logic               out_last;

  logic          req_fire, start, load_ok, we_a, we_b, we_p0, we_p1;
  logic          issue, elem_last, mult_last;
  logic [AW-1:0] load_addr, rd_addr, y_addr, wr_addr;
  logic [31:0]   a_x_rd, a_y_rd, b_rd, p0_rd, p1_rd, sat_value;
  logic signed [31:0] x_op, y_op;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:       prdata = {31'd0, mode};
      REG_ROWS_A:     prdata = {28'd0, rows_a};
      REG_INNER_SIZE: prdata = {28'd0, inner_size};
      REG_COLS_B:     prdata = {28'd0, cols_b};
      REG_POWER_EXP:  prdata = {24'd0, power_exponent};
      default:        prdata = 32'd0;
    endcase
  end

  // request decode
  assign req_fire  = req.valid && req.ready;
  assign start     = req_fire && (req.operation == OP_START);
  assign load_ok   = (int'(req.row_index) < MAX_DIM) && (int'(req.col_index) < MAX_DIM);
  assign load_addr = AW'(int'(req.row_index) * MAX_DIM + int'(req.col_index));
  assign we_a      = req_fire && (req.operation == OP_LOAD_A) && load_ok;
  assign we_b      = req_fire && (req.operation == OP_LOAD_B) && load_ok;

  assign elem_last = (row_cnt == m_last) && (col_cnt == p_last);
  assign mult_last = elem_last && (mults_left == 8'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (mode && (power_exponent <= 8'd1)) ? ST_ORD : ST_MAC;
        end
      end
      ST_MAC: begin
        if (k_cnt == k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !prod_vld) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = mult_last ? ST_ORD : ST_MAC;
      end
      ST_ORD: begin
        state_next = ST_OWAIT;
      end
      ST_OWAIT: begin
        state_next = ST_OSEND;
      end
      ST_OSEND: begin
        if (result.ready) begin
          state_next = out_last ? ST_IDLE : ST_ORD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready    = 1'b0;
    result.valid = 1'b0;
    issue        = 1'b0;
    we_p0        = 1'b0;
    we_p1        = 1'b0;
    unique case (state)
      ST_IDLE:  req.ready    = 1'b1;
      ST_MAC:   issue        = 1'b1;
      ST_WRITE: begin
        we_p0 = !dst_p1;
        we_p1 = dst_p1;
      end
      ST_OSEND: result.valid = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr = (state == ST_ORD) ? cell_addr(row_cnt, col_cnt) : cell_addr(row_cnt, k_cnt);
  assign y_addr  = cell_addr(k_cnt, col_cnt);
  assign wr_addr = cell_addr(row_cnt, col_cnt);
  assign src_sel = (state == ST_OWAIT) ? out_src : x_src;

  always_comb begin
    case (src_sel)
      SRC_A:   x_op = a_x_rd;
      SRC_P0:  x_op = p0_rd;
      SRC_P1:  x_op = p1_rd;
      default: x_op = a_x_rd;
    endcase
  end

  assign y_op       = mode ? a_y_rd : b_rd;
  assign mul_full   = x_op * y_op;
  assign prod_shift = prod >>> FRAC_BITS;

  always_comb begin
    if (acc[63:31] == '0 || acc[63:31] == '1) begin
      sat_value = acc[31:0];
    end else if (acc[63]) begin
      sat_value = 32'h8000_0000;
    end else begin
      sat_value = 32'h7FFF_FFFF;
    end
  end

  // storage
  mtxpow_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_a_x (
    .clk(clk), .we(we_a), .waddr(load_addr), .wdata(req.element_value),
    .raddr(rd_addr), .rdata(a_x_rd)
  );
  mtxpow_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_a_y (
    .clk(clk), .we(we_a), .waddr(load_addr), .wdata(req.element_value),
    .raddr(y_addr), .rdata(a_y_rd)
  );
  mtxpow_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_b (
    .clk(clk), .we(we_b), .waddr(load_addr), .wdata(req.element_value),
    .raddr(y_addr), .rdata(b_rd)
  );
  mtxpow_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_prod_0 (
    .clk(clk), .we(we_p0), .waddr(wr_addr), .wdata(sat_value),
    .raddr(rd_addr), .rdata(p0_rd)
  );
  mtxpow_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_prod_1 (
    .clk(clk), .we(we_p1), .waddr(wr_addr), .wdata(sat_value),
    .raddr(rd_addr), .rdata(p1_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= 1'b0;
      rows_a         <= 4'd1;
      inner_size     <= 4'd1;
      cols_b         <= 4'd1;
      power_exponent <= 8'd1;
      rd_vld         <= 1'b0;
      prod_vld       <= 1'b0;
      acc            <= '0;
      row_cnt        <= '0;
      col_cnt        <= '0;
      k_cnt          <= '0;
      mults_left     <= 8'd1;
      x_src          <= SRC_A;
      out_src        <= SRC_A;
      dst_p1         <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issue;
      prod_vld <= rd_vld;
      if (prod_vld) begin
        acc <= acc + prod_shift;
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          REG_MODE:       mode           <= pwdata[0];
          REG_ROWS_A:     rows_a         <= pwdata[3:0];
          REG_INNER_SIZE: inner_size     <= pwdata[3:0];
          REG_COLS_B:     cols_b         <= pwdata[3:0];
          REG_POWER_EXP:  power_exponent <= pwdata[7:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            row_cnt    <= '0;
            col_cnt    <= '0;
            k_cnt      <= '0;
            mults_left <= mode ? (power_exponent - 8'd1) : 8'd1;
            x_src      <= SRC_A;
            out_src    <= SRC_A;
            dst_p1     <= 1'b0;
          end
        end
        ST_MAC: begin
          k_cnt <= (k_cnt == k_last) ? '0 : k_cnt + 1'b1;
        end
        ST_WRITE: begin
          acc <= '0;
          if (col_cnt == p_last) begin
            col_cnt <= '0;
            row_cnt <= (row_cnt == m_last) ? '0 : row_cnt + 1'b1;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
          if (elem_last) begin
            if (mults_left == 8'd1) begin
              out_src <= dst_p1 ? SRC_P1 : SRC_P0;
            end else begin
              mults_left <= mults_left - 8'd1;
              x_src      <= dst_p1 ? SRC_P1 : SRC_P0;
              dst_p1     <= !dst_p1;
            end
          end
        end
        ST_OSEND: begin
          if (result.ready) begin
            if (col_cnt == p_last) begin
              col_cnt <= '0;
              row_cnt <= (row_cnt == m_last) ? '0 : row_cnt + 1'b1;
            end else begin
              col_cnt <= col_cnt + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_full;
    if (start) begin
      m_last <= dim_last(rows_a);
      k_last <= mode ? dim_last(rows_a) : dim_last(inner_size);
      p_last <= mode ? dim_last(rows_a) : dim_last(cols_b);
    end
    if (state == ST_OWAIT) begin
      out_value <= x_op;
      out_row   <= row_cnt;
      out_col   <= col_cnt;
      out_last  <= elem_last;
    end
  end

  assign result.result_value = out_value;
  assign result.result_row   = 3'(out_row);
  assign result.result_col   = 3'(out_col);
  assign result.last         = out_last;

endmodule
